[rtl/urx_pkg.sv]
// ============================================================================
// urx_pkg: shared types and constants of the UART receiver
// Frame phases, status codes, parity modes, register indexes and widths.
// ============================================================================
package urx_pkg;

    localparam int DATA_W     = 8;
    localparam int IDX_W      = $clog2(DATA_W);
    localparam int TICK_W     = 17;
    localparam int HALF_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_DATA,
        PH_PARITY,
        PH_STOP
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FRAMING,
        ST_PARITY
    } t_status;

    typedef enum logic [1:0] {
        PAR_NONE,
        PAR_EVEN,
        PAR_ODD
    } t_parity;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HALF_BIT,
        CFG_DATA_BITS,
        CFG_PARITY,
        CFG_STOP_BITS
    } t_cfg_addr;

    typedef struct packed {
        logic [HALF_W-1:0] half_ticks;
        logic [3:0]        data_bits;
        t_parity           parity;
        logic [1:0]        stop_bits;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
        t_status           status;
    } t_result;

endpackage

[rtl/urx_cfg.sv]
// ============================================================================
// urx_cfg: configuration registers
// Holds the four frame settings and presents their effective values.
// ============================================================================
module urx_cfg
    import urx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [HALF_W-1:0] r_half;
    logic [3:0]        r_data_bits;
    logic [1:0]        r_parity;
    logic [1:0]        r_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= HALF_W'(1093);
            r_data_bits <= 4'd8;
            r_parity    <= 2'd0;
            r_stop      <= 2'd1;
        end else if (i_cfg_we) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_HALF_BIT:  r_half      <= i_cfg_data[HALF_W-1:0];
                CFG_DATA_BITS: r_data_bits <= i_cfg_data[3:0];
                CFG_PARITY:    r_parity    <= i_cfg_data[1:0];
                CFG_STOP_BITS: r_stop      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.half_ticks = (r_half == '0) ? HALF_W'(1) : r_half;
        if (r_data_bits == 4'd0) begin
            o_cfg.data_bits = 4'd1;
        end else if (r_data_bits > 4'(DATA_W)) begin
            o_cfg.data_bits = 4'(DATA_W);
        end else begin
            o_cfg.data_bits = r_data_bits;
        end
        case (r_parity)
            2'd1:    o_cfg.parity = PAR_EVEN;
            2'd2:    o_cfg.parity = PAR_ODD;
            default: o_cfg.parity = PAR_NONE;
        endcase
        case (r_stop)
            2'd0:    o_cfg.stop_bits = 2'd1;
            2'd3:    o_cfg.stop_bits = 2'd2;
            default: o_cfg.stop_bits = r_stop;
        endcase
    end

endmodule

[rtl/urx_core.sv]
// ============================================================================
// urx_core: input register and frame state machine
// Registers each line sample and steps the frame decoder by one tick.
// ============================================================================
module urx_core
    import urx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_rx_valid,
    input  logic    i_rx_level,
    output logic    o_rx_ready,
    input  logic    i_out_free,
    output t_result o_result
);

    logic              r_in_valid;
    logic              r_in_level;
    t_phase            r_phase;
    t_phase            n_phase;
    logic [TICK_W-1:0] r_tick;
    logic [TICK_W-1:0] n_tick;
    logic [3:0]        r_bit;
    logic [3:0]        n_bit;
    logic [DATA_W-1:0] r_shift;
    logic [DATA_W-1:0] n_shift;
    logic              r_par_seen;
    logic              n_par_seen;

    logic              advance;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] half_t;
    logic [TICK_W-1:0] full_t;
    logic [3:0]        bit_inc;
    logic              expect_par;

    assign advance    = r_in_valid && i_out_free;
    assign o_rx_ready = !r_in_valid || i_out_free;
    assign tick_inc   = r_tick + TICK_W'(1);
    assign half_t     = {1'b0, i_cfg.half_ticks};
    assign full_t     = {i_cfg.half_ticks, 1'b0};
    assign bit_inc    = r_bit + 4'd1;
    assign expect_par = (^r_shift) ^ (i_cfg.parity == PAR_ODD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_tick     <= '0;
            r_bit      <= '0;
        end else begin
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_level <= i_rx_level;
        end
        r_shift    <= n_shift;
        r_par_seen <= n_par_seen;
    end

    always_comb begin
        n_phase         = r_phase;
        n_tick          = r_tick;
        n_bit           = r_bit;
        n_shift         = r_shift;
        n_par_seen      = r_par_seen;
        o_result.valid  = 1'b0;
        o_result.data   = '0;
        o_result.status = ST_OK;
        if (advance) begin
            case (r_phase)
                PH_IDLE: begin
                    if (!r_in_level) begin
                        n_phase = PH_START;
                        n_tick  = '0;
                    end
                end
                PH_START: begin
                    n_tick = tick_inc;
                    if (tick_inc >= half_t) begin
                        n_tick = '0;
                        n_bit  = '0;
                        if (r_in_level) begin
                            n_phase         = PH_IDLE;
                            o_result.valid  = 1'b1;
                            o_result.status = ST_FRAMING;
                        end else begin
                            n_phase    = PH_DATA;
                            n_shift    = '0;
                            n_par_seen = 1'b0;
                        end
                    end
                end
                PH_DATA: begin
                    n_tick = tick_inc;
                    if (tick_inc >= full_t) begin
                        n_tick = '0;
                        if (r_bit < 4'(DATA_W)) begin
                            n_shift[r_bit[IDX_W-1:0]] = r_shift[r_bit[IDX_W-1:0]] | r_in_level;
                        end
                        n_bit = bit_inc;
                        if (bit_inc >= i_cfg.data_bits) begin
                            n_bit   = '0;
                            n_phase = (i_cfg.parity != PAR_NONE) ? PH_PARITY : PH_STOP;
                        end
                    end
                end
                PH_PARITY: begin
                    n_tick = tick_inc;
                    if (tick_inc >= full_t) begin
                        n_tick     = '0;
                        n_par_seen = r_in_level;
                        n_bit      = '0;
                        n_phase    = PH_STOP;
                    end
                end
                PH_STOP: begin
                    n_tick = tick_inc;
                    if (tick_inc >= full_t) begin
                        n_tick = '0;
                        if (!r_in_level) begin
                            n_phase         = PH_IDLE;
                            n_bit           = '0;
                            o_result.valid  = 1'b1;
                            o_result.status = ST_FRAMING;
                        end else if (bit_inc < {2'b00, i_cfg.stop_bits}) begin
                            n_bit = bit_inc;
                        end else begin
                            n_phase        = PH_IDLE;
                            n_bit          = '0;
                            o_result.valid = 1'b1;
                            o_result.data  = r_shift;
                            if (i_cfg.parity != PAR_NONE && expect_par != r_par_seen) begin
                                o_result.status = ST_PARITY;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                    n_bit   = '0;
                end
            endcase
        end
    end

endmodule

[rtl/urx_out.sv]
// ============================================================================
// urx_out: result register
// Holds one received word until the consumer takes it.
// ============================================================================
module urx_out
    import urx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_result           i_result,
    output logic              o_free,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [DATA_W-1:0] o_rx_byte,
    output logic [1:0]        o_rx_status
);

    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    t_status           r_status;

    assign o_free      = !r_valid || i_res_ready;
    assign o_res_valid = r_valid;
    assign o_rx_byte   = r_data;
    assign o_rx_status = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_result.valid) begin
            r_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_data   <= i_result.data;
            r_status <= i_result.status;
        end
    end

endmodule

[rtl/uart_receiver.sv]
// ============================================================================
// uart_receiver: serial receive decoder, one line sample per word
// Top level joining configuration, frame decoder and result register.
// ============================================================================
// Each input word is one sample of the receive line, and one is taken every
// clock cycle while the result register can make room. A sample passes the
// input register, steps the frame decoder, and any finished frame is then
// registered in the result register. A frame gives one result word: the data
// byte and a status of ok, framing error (byte zero) or parity error. The
// half-bit tick count, data bits, parity mode and stop bits are written
// through the configuration port; the user must write them only while no
// frame is in progress, which the block itself does not enforce.
module uart_receiver
    import urx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_rx_valid,
    output logic                  o_rx_ready,
    input  logic                  i_rx_level,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [DATA_W-1:0]     o_rx_byte,
    output logic [1:0]            o_rx_status
);

    t_cfg    cfg;
    t_result result;
    logic    out_free;

    urx_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    urx_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_rx_valid (i_rx_valid),
        .i_rx_level (i_rx_level),
        .o_rx_ready (o_rx_ready),
        .i_out_free (out_free),
        .o_result   (result)
    );

    urx_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .o_free      (out_free),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_rx_byte   (o_rx_byte),
        .o_rx_status (o_rx_status)
    );

endmodule

[rtl/urx_checker.sv]
// ============================================================================
// urx_checker: port checks for the UART receiver
// Concurrent assertions on the top-level ports, attached by bind.
// ============================================================================
module urx_checker
    import urx_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_rx_ready,
    input logic                  o_res_valid,
    input logic                  i_res_ready,
    input logic [DATA_W-1:0]     o_rx_byte,
    input logic [1:0]            o_rx_status
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=>
            o_res_valid && $stable(o_rx_byte) && $stable(o_rx_status))
        else $error("result word changed while stalled");

    a_framing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_rx_status == ST_FRAMING |-> o_rx_byte == '0)
        else $error("framing error carries a nonzero byte");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res_valid |-> o_rx_ready)
        else $error("sample refused while the result register is empty");

    a_reset_clear: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_res_valid)
        else $error("result valid after reset");

endmodule

bind uart_receiver urx_checker u_urx_checker (.*);
